FILE: src/clc_pkg.sv
package clc_pkg;

	localparam int DATA_W  = 32;
	localparam int SIZE_W  = 5;
	localparam int INDEX_W = 4;
	localparam int IDX_W   = 6;
	localparam int OP_W    = 4;

	localparam logic [OP_W-1:0] OP_NONE    = 4'd0;
	localparam logic [OP_W-1:0] OP_ACC_CLR = 4'd1;
	localparam logic [OP_W-1:0] OP_ACC_VEC = 4'd2;
	localparam logic [OP_W-1:0] OP_OPA     = 4'd3;
	localparam logic [OP_W-1:0] OP_MUL_MAT = 4'd4;
	localparam logic [OP_W-1:0] OP_MUL_VEC = 4'd5;
	localparam logic [OP_W-1:0] OP_TERM    = 4'd6;
	localparam logic [OP_W-1:0] OP_ADD     = 4'd7;
	localparam logic [OP_W-1:0] OP_SUB     = 4'd8;
	localparam logic [OP_W-1:0] OP_DIFF    = 4'd9;

	typedef struct packed {
		logic               mat_re;
		logic               mat_we;
		logic               mat_wsel_in;
		logic [IDX_W-1:0]   mat_row;
		logic [IDX_W-1:0]   mat_col;
		logic               vec_re;
		logic               vec_we;
		logic               vec_wsel_in;
		logic [IDX_W-1:0]   vec_idx;
		logic [OP_W-1:0]    op;
		logic               start_sqrt;
		logic               start_div;
		logic               err_clr;
		logic               out_load;
		logic               out_last;
		logic [INDEX_W-1:0] out_idx;
	} clc_cmd_t;

	typedef struct packed {
		logic unit_done;
	} clc_stat_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > 64'sh000000007fffffff)
			r = 32'sh7fffffff;
		else if (v < -64'sh0000000080000000)
			r = 32'sh80000000;
		else
			r = v[DATA_W-1:0];
		return r;
	endfunction

endpackage

FILE: src/clc_elem_if.sv
interface clc_elem_if;
	import clc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] element_value;
	modport source (output valid, output element_value, input ready);
	modport sink (input valid, input element_value, output ready);
endinterface

FILE: src/clc_sol_if.sv
interface clc_sol_if;
	import clc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] solution_value;
	logic [INDEX_W-1:0]       solution_index;
	logic                     last_result;
	logic                     pivot_error;
	modport source (output valid, output solution_value, output solution_index,
		output last_result, output pivot_error, input ready);
	modport sink (input valid, input solution_value, input solution_index,
		input last_result, input pivot_error, output ready);
endinterface

FILE: src/clc_iter.sv
module clc_iter #(
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start_sqrt,
	input  logic                          start_div,
	input  logic signed [clc_pkg::DATA_W-1:0] opa,
	input  logic signed [clc_pkg::DATA_W-1:0] opb,
	output logic                          done,
	output logic                          fault,
	output logic signed [clc_pkg::DATA_W-1:0] result
);
	import clc_pkg::*;

	logic        busy_q, done_q, fault_q, sqrt_q, neg_q;
	logic [6:0]  cnt_q;
	logic [35:0] rem_q;
	logic [63:0] shr_q, quo_q;
	logic [32:0] dvs_q;
	logic signed [DATA_W-1:0] res_q;

	logic [35:0] rem2, trial, drem, rem_nx;
	logic        ge;
	logic [32:0] mag_a, mag_b;
	logic signed [DATA_W-1:0] fin;

	always_comb begin
		rem2  = {rem_q[33:0], shr_q[63:62]};
		trial = {quo_q[33:0], 2'b01};
		drem  = {rem_q[34:0], shr_q[63]};
		if (sqrt_q) begin
			ge     = rem2 >= trial;
			rem_nx = ge ? rem2 - trial : rem2;
		end else begin
			ge     = drem >= {3'b000, dvs_q};
			rem_nx = ge ? drem - {3'b000, dvs_q} : drem;
		end
		mag_a = opa[DATA_W-1] ? 33'd0 - {opa[DATA_W-1], opa} : {1'b0, opa};
		mag_b = opb[DATA_W-1] ? 33'd0 - {opb[DATA_W-1], opb} : {1'b0, opb};
		if (sqrt_q)
			fin = quo_q[DATA_W-1:0];
		else if (neg_q)
			fin = (quo_q > 64'h0000000080000000) ? 32'sh80000000 : 32'sd0 - quo_q[DATA_W-1:0];
		else
			fin = (quo_q > 64'h000000007fffffff) ? 32'sh7fffffff : quo_q[DATA_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			fault_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q  <= 1'b0;
			fault_q <= 1'b0;
			if (start_sqrt) begin
				if (opa <= 0) begin
					done_q  <= 1'b1;
					fault_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= 7'd32;
				end
			end else if (start_div) begin
				if (opb == 0) begin
					done_q  <= 1'b1;
					fault_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= 7'd64;
				end
			end else if (busy_q) begin
				if (cnt_q == 7'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 7'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_sqrt) begin
			sqrt_q <= 1'b1;
			rem_q  <= '0;
			quo_q  <= '0;
			shr_q  <= {32'd0, opa} << FRAC_BITS;
			res_q  <= '0;
		end else if (start_div) begin
			sqrt_q <= 1'b0;
			neg_q  <= opa[DATA_W-1] ^ opb[DATA_W-1];
			rem_q  <= '0;
			quo_q  <= '0;
			shr_q  <= {31'd0, mag_a} << FRAC_BITS;
			dvs_q  <= mag_b;
			res_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == 7'd0) begin
				res_q <= fin;
			end else begin
				rem_q <= rem_nx;
				quo_q <= {quo_q[62:0], ge};
				shr_q <= sqrt_q ? {shr_q[61:0], 2'b00} : {shr_q[62:0], 1'b0};
			end
		end
	end

	assign done   = done_q;
	assign fault  = fault_q;
	assign result = res_q;

endmodule

FILE: src/clc_dp.sv
module clc_dp #(
	parameter int MAX_SIZE  = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  clc_pkg::clc_cmd_t                 cmd,
	output clc_pkg::clc_stat_t                stat,
	input  logic signed [clc_pkg::DATA_W-1:0] in_value,
	output logic signed [clc_pkg::DATA_W-1:0] out_value,
	output logic [clc_pkg::INDEX_W-1:0]       out_index,
	output logic                              out_last,
	output logic                              out_err
);
	import clc_pkg::*;

	localparam int IW = $clog2(MAX_SIZE);
	localparam int AW = 2 * IW;

	logic signed [DATA_W-1:0] mat_mem [0:(1 << AW)-1];
	logic signed [DATA_W-1:0] vec_mem [0:(1 << IW)-1];
	logic signed [DATA_W-1:0] mat_rd_q, vec_rd_q, opa_q, acc_q, term_s2;
	logic signed [63:0]       prod_s1;
	logic                     err_q;
	logic [AW-1:0]            maddr;
	logic [IW-1:0]            vaddr;
	logic signed [DATA_W-1:0] mwd, vwd, unit_res;
	logic                     unit_done, unit_fault;
	logic signed [DATA_W-1:0] ov_q;
	logic [INDEX_W-1:0]       oi_q;
	logic                     ol_q, oe_q;

	assign maddr = {cmd.mat_row[IW-1:0], cmd.mat_col[IW-1:0]};
	assign vaddr = cmd.vec_idx[IW-1:0];
	assign mwd   = cmd.mat_wsel_in ? in_value : unit_res;
	assign vwd   = cmd.vec_wsel_in ? in_value : unit_res;

	always_ff @(posedge clk) begin
		if (cmd.mat_we)
			mat_mem[maddr] <= mwd;
		if (cmd.mat_re)
			mat_rd_q <= mat_mem[maddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.vec_we)
			vec_mem[vaddr] <= vwd;
		if (cmd.vec_re)
			vec_rd_q <= vec_mem[vaddr];
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_ACC_CLR: acc_q <= '0;
			OP_ACC_VEC: acc_q <= vec_rd_q;
			OP_OPA:     opa_q <= mat_rd_q;
			OP_MUL_MAT: prod_s1 <= opa_q * mat_rd_q;
			OP_MUL_VEC: prod_s1 <= opa_q * vec_rd_q;
			OP_TERM:    term_s2 <= sat32(prod_s1 >>> FRAC_BITS);
			OP_ADD:     acc_q <= sat32(64'(acc_q) + 64'(term_s2));
			OP_SUB:     acc_q <= sat32(64'(acc_q) - 64'(term_s2));
			OP_DIFF:    acc_q <= sat32(64'(mat_rd_q) - 64'(acc_q));
			default: ;
		endcase
		if (cmd.out_load) begin
			ov_q <= err_q ? '0 : vec_rd_q;
			oi_q <= cmd.out_idx;
			ol_q <= cmd.out_last;
			oe_q <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			err_q <= 1'b0;
		else if (cmd.err_clr)
			err_q <= 1'b0;
		else if (unit_done && unit_fault)
			err_q <= 1'b1;
	end

	clc_iter #(.FRAC_BITS(FRAC_BITS)) u_iter (
		.clk        (clk),
		.arst_n     (arst_n),
		.start_sqrt (cmd.start_sqrt),
		.start_div  (cmd.start_div),
		.opa        (acc_q),
		.opb        (mat_rd_q),
		.done       (unit_done),
		.fault      (unit_fault),
		.result     (unit_res)
	);

	assign stat.unit_done = unit_done;
	assign out_value = ov_q;
	assign out_index = oi_q;
	assign out_last  = ol_q;
	assign out_err   = oe_q;

endmodule

FILE: src/clc_ctrl.sv
module clc_ctrl #(
	parameter int MAX_SIZE = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [clc_pkg::SIZE_W-1:0]       cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	output logic                             out_valid,
	input  logic                             out_ready,
	output clc_pkg::clc_cmd_t                cmd,
	input  clc_pkg::clc_stat_t               stat
);
	import clc_pkg::*;

	localparam int NW = $clog2(MAX_SIZE + 1);

	localparam logic [4:0] S_LOAD  = 5'd0;
	localparam logic [4:0] S_INIT  = 5'd1;
	localparam logic [4:0] S_LDV   = 5'd2;
	localparam logic [4:0] S_CHK   = 5'd3;
	localparam logic [4:0] S_TA    = 5'd4;
	localparam logic [4:0] S_TB    = 5'd5;
	localparam logic [4:0] S_TM    = 5'd6;
	localparam logic [4:0] S_TT    = 5'd7;
	localparam logic [4:0] S_TS    = 5'd8;
	localparam logic [4:0] S_DR    = 5'd9;
	localparam logic [4:0] S_DD    = 5'd10;
	localparam logic [4:0] S_PR    = 5'd11;
	localparam logic [4:0] S_PG    = 5'd12;
	localparam logic [4:0] S_PW    = 5'd13;
	localparam logic [4:0] S_WR    = 5'd14;
	localparam logic [4:0] S_ORD   = 5'd15;
	localparam logic [4:0] S_OSET  = 5'd16;
	localparam logic [4:0] S_OWAIT = 5'd17;

	localparam logic [1:0] PH_FAC = 2'd0;
	localparam logic [1:0] PH_FWD = 2'd1;
	localparam logic [1:0] PH_BWD = 2'd2;

	logic [4:0]        state_q, state_d;
	logic [1:0]        ph_q, ph_d;
	logic [SIZE_W-1:0] size_q;
	logic [NW-1:0]     row_q, row_d, col_q, col_d, i_q, i_d, j_q, j_d, k_q, k_d;
	logic              ov_q, ov_d;
	logic [NW-1:0]     n, kend, r, c, r1, c1;
	logic              accept, fac;

	assign n = (size_q == '0) ? NW'(1) :
		((32'(size_q) > MAX_SIZE) ? NW'(MAX_SIZE) : NW'(size_q));
	assign fac      = ph_q == PH_FAC;
	assign kend     = fac ? j_q : ((ph_q == PH_FWD) ? i_q : n);
	assign in_ready = state_q == S_LOAD;
	assign accept   = in_ready && in_valid;
	assign r  = (row_q >= n || col_q > n) ? '0 : row_q;
	assign c  = (row_q >= n || col_q > n) ? '0 : col_q;
	assign r1 = r + 1'b1;
	assign c1 = c + 1'b1;

	always_comb begin
		state_d = state_q;
		ph_d    = ph_q;
		row_d   = row_q;
		col_d   = col_q;
		i_d     = i_q;
		j_d     = j_q;
		k_d     = k_q;
		ov_d    = ov_q;
		cmd     = '0;
		case (state_q)
			S_LOAD: begin
				if (accept) begin
					cmd.mat_wsel_in = 1'b1;
					cmd.vec_wsel_in = 1'b1;
					cmd.mat_row     = IDX_W'(r);
					cmd.mat_col     = IDX_W'(c);
					cmd.vec_idx     = IDX_W'(r);
					cmd.mat_we      = c < n;
					cmd.vec_we      = !(c < n);
					if (c1 <= n) begin
						row_d = r;
						col_d = c1;
					end else begin
						col_d = '0;
						if (r1 < n) begin
							row_d = r1;
						end else begin
							row_d       = '0;
							cmd.err_clr = 1'b1;
							ph_d        = PH_FAC;
							i_d         = '0;
							j_d         = '0;
							state_d     = S_INIT;
						end
					end
				end
			end
			S_INIT: begin
				cmd.op      = OP_ACC_CLR;
				cmd.vec_re  = 1'b1;
				cmd.vec_idx = IDX_W'(i_q);
				k_d         = (ph_q == PH_BWD) ? i_q + 1'b1 : '0;
				state_d     = S_LDV;
			end
			S_LDV: begin
				if (!fac)
					cmd.op = OP_ACC_VEC;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (k_q < kend)
					state_d = S_TA;
				else
					state_d = fac ? S_DR : S_PR;
			end
			S_TA: begin
				cmd.mat_re  = 1'b1;
				cmd.mat_row = IDX_W'((ph_q == PH_BWD) ? k_q : i_q);
				cmd.mat_col = IDX_W'((ph_q == PH_BWD) ? i_q : k_q);
				state_d     = S_TB;
			end
			S_TB: begin
				cmd.op      = OP_OPA;
				cmd.mat_re  = fac;
				cmd.vec_re  = !fac;
				cmd.mat_row = IDX_W'(j_q);
				cmd.mat_col = IDX_W'(k_q);
				cmd.vec_idx = IDX_W'(k_q);
				state_d     = S_TM;
			end
			S_TM: begin
				cmd.op  = fac ? OP_MUL_MAT : OP_MUL_VEC;
				state_d = S_TT;
			end
			S_TT: begin
				cmd.op  = OP_TERM;
				state_d = S_TS;
			end
			S_TS: begin
				cmd.op  = fac ? OP_ADD : OP_SUB;
				k_d     = k_q + 1'b1;
				state_d = S_CHK;
			end
			S_DR: begin
				cmd.mat_re  = 1'b1;
				cmd.mat_row = IDX_W'(i_q);
				cmd.mat_col = IDX_W'(j_q);
				state_d     = S_DD;
			end
			S_DD: begin
				cmd.op  = OP_DIFF;
				state_d = (i_q == j_q) ? S_PG : S_PR;
			end
			S_PR: begin
				cmd.mat_re  = 1'b1;
				cmd.mat_row = IDX_W'(fac ? j_q : i_q);
				cmd.mat_col = IDX_W'(fac ? j_q : i_q);
				state_d     = S_PG;
			end
			S_PG: begin
				if (fac && i_q == j_q)
					cmd.start_sqrt = 1'b1;
				else
					cmd.start_div = 1'b1;
				state_d = S_PW;
			end
			S_PW: begin
				if (stat.unit_done)
					state_d = S_WR;
			end
			S_WR: begin
				cmd.mat_row = IDX_W'(i_q);
				cmd.mat_col = IDX_W'(j_q);
				cmd.vec_idx = IDX_W'(i_q);
				cmd.mat_we  = fac;
				cmd.vec_we  = !fac;
				state_d     = S_INIT;
				case (ph_q)
					PH_FAC: begin
						if (j_q < i_q) begin
							j_d = j_q + 1'b1;
						end else if (i_q + 1'b1 < n) begin
							i_d = i_q + 1'b1;
							j_d = '0;
						end else begin
							ph_d = PH_FWD;
							i_d  = '0;
						end
					end
					PH_FWD: begin
						if (i_q + 1'b1 < n) begin
							i_d = i_q + 1'b1;
						end else begin
							ph_d = PH_BWD;
							i_d  = n - 1'b1;
						end
					end
					default: begin
						if (i_q != '0) begin
							i_d = i_q - 1'b1;
						end else begin
							i_d     = '0;
							state_d = S_ORD;
						end
					end
				endcase
			end
			S_ORD: begin
				cmd.vec_re  = 1'b1;
				cmd.vec_idx = IDX_W'(i_q);
				state_d     = S_OSET;
			end
			S_OSET: begin
				cmd.out_load = 1'b1;
				cmd.out_idx  = INDEX_W'(i_q);
				cmd.out_last = (i_q + 1'b1) == n;
				ov_d         = 1'b1;
				state_d      = S_OWAIT;
			end
			S_OWAIT: begin
				if (out_ready) begin
					ov_d = 1'b0;
					if (i_q + 1'b1 < n) begin
						i_d     = i_q + 1'b1;
						state_d = S_ORD;
					end else begin
						i_d     = '0;
						state_d = S_LOAD;
					end
				end
			end
			default: state_d = S_LOAD;
		endcase
		if (cfg_we) begin
			row_d = '0;
			col_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			ph_q    <= PH_FAC;
			size_q  <= SIZE_W'(16);
			row_q   <= '0;
			col_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			ph_q    <= ph_d;
			row_q   <= row_d;
			col_q   <= col_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
			ov_q    <= ov_d;
			if (cfg_we)
				size_q <= cfg_data;
		end
	end

	assign out_valid = ov_q;

endmodule

FILE: src/cholesky_linear_solver_core.sv
// channel   dir  payload                                           handshake
// elem      in   element_value                                     valid/ready
// sol       out  solution_value, solution_index, last_result,      valid/ready
//                pivot_error
// cfg       in   cfg_data (matrix_size)                            cfg_we
//
// loading takes one cycle per item; ready stays low from the last item until
// all results are taken
// solve: factor entry by entry, then substitute forward and back; each entry or
// step sums multiply-accumulate terms, then runs a square root or division that
// stops at once on a pivot fault; each result is read out and held until taken
// arst_n clears control state; the matrix and vector memories are not cleared
module cholesky_linear_solver_core #(
	parameter int MAX_SIZE  = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [clc_pkg::SIZE_W-1:0]  cfg_data,
	clc_elem_if.sink                    elem,
	clc_sol_if.source                   sol
);
	import clc_pkg::*;

	clc_cmd_t  cmd;
	clc_stat_t stat;

	clc_ctrl #(.MAX_SIZE(MAX_SIZE)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_valid  (elem.valid),
		.in_ready  (elem.ready),
		.out_valid (sol.valid),
		.out_ready (sol.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	clc_dp #(.MAX_SIZE(MAX_SIZE), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_value  (elem.element_value),
		.out_value (sol.solution_value),
		.out_index (sol.solution_index),
		.out_last  (sol.last_result),
		.out_err   (sol.pivot_error)
	);

endmodule

FILE: sim/tb_cholesky_linear_solver_core.sv
module tb_cholesky_linear_solver_core;
	import clc_pkg::*;

	localparam int N_MAX = 16;
	localparam int FRAC = 16;
	localparam int ONE = 1 << FRAC;
	localparam int IDLE_LIMIT = 200000;

	typedef struct {
		logic signed [DATA_W-1:0] value;
		logic [INDEX_W-1:0]       index;
		logic                     fin;
		logic                     err;
	} solution_t;

	typedef struct {
		logic [SIZE_W-1:0] size;
		logic [31:0]       value;
		bit                typed;
		logic [31:0]       x_value;
		bit                x_err;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [SIZE_W-1:0] cfg_data;

	clc_elem_if elem ();
	clc_sol_if sol ();

	cholesky_linear_solver_core #(
		.MAX_SIZE(N_MAX),
		.FRAC_BITS(FRAC)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.elem(elem.sink),
		.sol(sol.source)
	);

	// predictor state
	logic [SIZE_W-1:0] size_reg;
	logic signed [31:0] a_mem [N_MAX][N_MAX];
	logic signed [31:0] b_mem [N_MAX];
	logic signed [31:0] l_fac [N_MAX][N_MAX];
	logic signed [31:0] y_vec [N_MAX];
	logic signed [31:0] x_vec [N_MAX];
	int row_ptr, col_ptr;
	bit div_err;

	solution_t solutions_due [$];
	int fail_count, results_seen, items_sent, systems_solved, error_systems;
	int idle_cycles;
	bit calm_in, calm_out;

	function automatic logic signed [31:0] clip(input longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] q_mul(input logic signed [31:0] a,
		input logic signed [31:0] b);
		longint p;
		p = longint'(a) * longint'(b);
		return clip(p >>> FRAC);
	endfunction

	function automatic logic signed [31:0] q_div(input logic signed [31:0] num,
		input logic signed [31:0] den);
		longint q;
		if (den == 0) begin
			div_err = 1;
			return 0;
		end
		q = (longint'(num) * (64'sd1 << FRAC)) / longint'(den);
		return clip(q);
	endfunction

	function automatic logic [31:0] root64(input longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r[31:0];
	endfunction

	function automatic int live_size();
		if (size_reg < 1)
			return 1;
		if (size_reg > N_MAX)
			return N_MAX;
		return size_reg;
	endfunction

	task automatic solve_system(input int n);
		logic signed [31:0] s, d;
		solution_t r;
		div_err = 0;
		for (int i = 0; i < n; i++)
			for (int j = 0; j <= i; j++) begin
				s = 0;
				for (int k = 0; k < j; k++)
					s = clip(longint'(s) + q_mul(l_fac[i][k], l_fac[j][k]));
				d = clip(longint'(a_mem[i][j]) - s);
				if (i == j) begin
					if (d <= 0) begin
						div_err = 1;
						l_fac[i][i] = 0;
					end else begin
						l_fac[i][i] = root64(longint'(d) << FRAC);
					end
				end else begin
					l_fac[i][j] = q_div(d, l_fac[j][j]);
				end
			end
		for (int i = 0; i < n; i++) begin
			s = b_mem[i];
			for (int k = 0; k < i; k++)
				s = clip(longint'(s) - q_mul(l_fac[i][k], y_vec[k]));
			y_vec[i] = q_div(s, l_fac[i][i]);
		end
		for (int i = n - 1; i >= 0; i--) begin
			s = y_vec[i];
			for (int k = i + 1; k < n; k++)
				s = clip(longint'(s) - q_mul(l_fac[k][i], x_vec[k]));
			x_vec[i] = q_div(s, l_fac[i][i]);
		end
		for (int i = 0; i < n; i++) begin
			r.value = div_err ? 0 : x_vec[i];
			r.index = i[INDEX_W-1:0];
			r.fin = (i == n - 1);
			r.err = div_err;
			solutions_due = {solutions_due, r};
		end
		systems_solved++;
		if (div_err)
			error_systems++;
	endtask

	task automatic load_element(input logic signed [31:0] v);
		int n;
		n = live_size();
		if (row_ptr >= n || col_ptr > n) begin
			row_ptr = 0;
			col_ptr = 0;
		end
		if (col_ptr < n)
			a_mem[row_ptr][col_ptr] = v;
		else
			b_mem[row_ptr] = v;
		col_ptr++;
		if (col_ptr > n) begin
			col_ptr = 0;
			row_ptr++;
			if (row_ptr >= n) begin
				row_ptr = 0;
				solve_system(n);
			end
		end
	endtask

	task automatic send_element(input logic [31:0] v);
		int gap;
		gap = calm_in ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			elem.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		elem.valid <= 1'b1;
		elem.element_value <= v;
		do @(posedge clk); while (!elem.ready);
		items_sent++;
		load_element(v);
	endtask

	task automatic drain();
		elem.valid <= 1'b0;
		wait (solutions_due.size() == 0);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_size(input logic [SIZE_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		size_reg = v;
		row_ptr = 0;
		col_ptr = 0;
	endtask

	function automatic logic [31:0] small_val(input int span);
		return $urandom_range(0, 2 * span) - span;
	endfunction

	task automatic send_spd(input int n, input bit noisy);
		logic signed [31:0] m [N_MAX][N_MAX];
		for (int i = 0; i < n; i++)
			for (int j = 0; j <= i; j++) begin
				m[i][j] = noisy ? $urandom : small_val(ONE);
				if (i == j && !noisy)
					m[i][i] = n * ONE + $urandom_range(1, 2 * ONE);
				m[j][i] = m[i][j];
			end
		for (int i = 0; i < n; i++) begin
			for (int j = 0; j < n; j++)
				send_element(m[i][j]);
			send_element(noisy ? $urandom : small_val(8 * ONE));
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// solution side: random stalls, compare on every accepted item
	initial begin
		int gap;
		solution_t got, want;
		sol.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = calm_out ? 0 : $urandom_range(0, 18);
			if (gap > 0) begin
				sol.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			sol.ready <= 1'b1;
			do @(posedge clk); while (!sol.valid);
			got.value = sol.solution_value;
			got.index = sol.solution_index;
			got.fin = sol.last_result;
			got.err = sol.pivot_error;
			results_seen++;
			if (solutions_due.size() == 0) begin
				$display("%0t: unexpected solution value %h index %0d", $time,
					got.value, got.index);
				fail_count++;
			end else begin
				want = solutions_due.pop_front();
				if (got.value !== want.value) begin
					$display("%0t: solution_value expected %h actual %h", $time,
						want.value, got.value);
					fail_count++;
				end
				if (got.index !== want.index) begin
					$display("%0t: solution_index expected %0d actual %0d", $time,
						want.index, got.index);
					fail_count++;
				end
				if (got.fin !== want.fin) begin
					$display("%0t: last_result expected %b actual %b", $time,
						want.fin, got.fin);
					fail_count++;
				end
				if (got.err !== want.err) begin
					$display("%0t: pivot_error expected %b actual %b", $time,
						want.err, got.err);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((elem.valid && elem.ready) || (sol.valid && sol.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, idle_cycles);
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		stim_row_t plan [16];
		int n, pick;
		plan = '{
			'{5'd1, 32'h00010000, 0, 0, 0}, '{5'd1, 32'h00020000, 1, 32'h00020000, 0},
			'{5'd1, 32'h00000000, 0, 0, 0}, '{5'd1, 32'h00050000, 1, 0, 1},
			'{5'd1, 32'hffff0000, 0, 0, 0}, '{5'd1, 32'h00000001, 1, 0, 1},
			'{5'd1, 32'h7fffffff, 0, 0, 0}, '{5'd1, 32'h80000000, 0, 0, 0},
			'{5'd1, 32'h80000000, 0, 0, 0}, '{5'd1, 32'h7fffffff, 1, 0, 1},
			'{5'd0, 32'h00040000, 0, 0, 0}, '{5'd0, 32'h00080000, 1, 32'h00020000, 0},
			'{5'd2, 32'h00040000, 0, 0, 0}, '{5'd2, 32'h00020000, 0, 0, 0},
			'{5'd2, 32'h00020000, 0, 0, 0}, '{5'd2, 32'h00020000, 0, 0, 0}
		};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		elem.valid = 1'b0;
		elem.element_value = '0;
		calm_in = 0;
		calm_out = 0;
		fail_count = 0;
		results_seen = 0;
		items_sent = 0;
		systems_solved = 0;
		error_systems = 0;
		idle_cycles = 0;
		size_reg = N_MAX;
		row_ptr = 0;
		col_ptr = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_size(plan[0].size);
		foreach (plan[r]) begin
			if (plan[r].size != size_reg) begin
				drain();
				write_size(plan[r].size);
			end
			send_element(plan[r].value);
			if (plan[r].typed) begin
				solutions_due[solutions_due.size() - 1].value = plan[r].x_value;
				solutions_due[solutions_due.size() - 1].err = plan[r].x_err;
			end
		end
		// last two items of the 2x2 system
		send_element(32'h00030000);
		send_element(32'h00010000);

		// random small systems
		while (items_sent < 270) begin
			drain();
			calm_in = ($urandom_range(0, 4) == 0);
			calm_out = ($urandom_range(0, 4) == 0);
			pick = $urandom_range(0, 19);
			write_size(SIZE_W'($urandom_range(0, 4)));
			n = live_size();
			if (pick == 0) begin
				// load of random items; a partial one is dropped by the next size write
				repeat ($urandom_range(1, n * (n + 1) - 1 + (n == 1)))
					send_element($urandom);
				continue;
			end
			repeat ($urandom_range(1, 3))
				send_spd(n, pick < 4);
		end

		drain();
		$display("systems solved %0d (%0d with pivot error), items %0d, solutions %0d",
			systems_solved, error_systems, items_sent, results_seen);
		if (fail_count == 0 && solutions_due.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
